// ----- src/bfd_pkg.sv -----
// Package with the word types, result codes and queue event type of the binary frame deframer.
package bfd_pkg;

  localparam int unsigned HeaderBytes = 32;
  localparam int unsigned CfgIdxW     = 1;

  localparam logic [CfgIdxW-1:0] CfgMagic   = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgVersion = 1'b1;

  typedef enum logic [1:0] {
    KindHeader = 2'd0,
    KindLogit  = 2'd1,
    KindEnd    = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    StatClean      = 3'd0,
    StatBadMagic   = 3'd1,
    StatBadVersion = 3'd2,
    StatBadCount   = 3'd3,
    StatTruncated  = 3'd4
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } in_t;

  typedef struct packed {
    kind_e              kind;
    logic [63:0]        sequence_number;
    logic signed [31:0] time_bin;
    logic signed [31:0] valid_word;
    logic signed [31:0] label_value;
    logic [16:0]        label_count;
    logic [15:0]        logit_index;
    logic [63:0]        logit_bits;
    logic [31:0]        frame_count;
    status_e            status;
    logic               last;
  } out_t;

  typedef struct packed {
    logic        has_main;
    out_t        main;
    logic        has_end;
    logic [31:0] frame_count;
    status_e     status;
  } event_t;

endpackage

// ----- src/bfd_front.sv -----
// Byte parser of the deframer: header assembly and checks, logit assembly, end handling.
module bfd_front #(
  parameter int unsigned MAX_LABELS  = 65536,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [bfd_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [31:0]                 cfg_data_i,
  input  logic                        in_valid_i,
  input  bfd_pkg::in_t                in_data_i,
  input  logic                        q_full_i,
  output logic                        push_o,
  output bfd_pkg::event_t             event_o
);

  localparam int unsigned CntW = (COUNT_WIDTH < 32) ? COUNT_WIDTH : 32;
  localparam logic [CntW-1:0] CntMax = '1;

  logic [31:0]       magic_q;
  logic [15:0]       version_q;
  logic [5:0]        ho_q, ho_d;
  logic [16:0]       lc_q, lc_d;
  logic [2:0]        biw_q, biw_d;
  logic [63:0]       asm_q, asm_d;
  logic [47:0]       hf0_q, hf0_d;
  logic [63:0]       hf1_q, hf1_d;
  logic [63:0]       hf2_q, hf2_d;
  logic [16:0]       k_q, k_d;
  logic [CntW-1:0]   frames_q, frames_d;
  bfd_pkg::status_e  fail_q, fail_d;
  logic              accept;

  assign accept = in_valid_i && !q_full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q   <= '0;
      version_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bfd_pkg::CfgMagic:   magic_q   <= cfg_data_i;
        bfd_pkg::CfgVersion: version_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [63:0] asm_new;
    logic        complete;
    logic [31:0] k;
    logic [16:0] lc_next;
    bfd_pkg::out_t main;
    ho_d     = ho_q;
    lc_d     = lc_q;
    biw_d    = biw_q;
    asm_d    = asm_q;
    hf0_d    = hf0_q;
    hf1_d    = hf1_q;
    hf2_d    = hf2_q;
    k_d      = k_q;
    frames_d = frames_q;
    fail_d   = fail_q;
    main     = '0;
    event_o  = '0;
    asm_new  = {in_data_i.data_byte, asm_q[63:8]};
    complete = (biw_q == 3'd7);
    k        = asm_new[63:32];
    lc_next  = lc_q + 17'd1;

    if (fail_q == bfd_pkg::StatClean) begin
      asm_d = asm_new;
      biw_d = biw_q + 3'd1;
      if (ho_q < 6'(bfd_pkg::HeaderBytes)) begin
        if (complete) begin
          case (ho_q[4:3])
            2'd0:    hf0_d = asm_new[47:0];
            2'd1:    hf1_d = asm_new;
            2'd2:    hf2_d = asm_new;
            default: ;
          endcase
        end
        ho_d = ho_q + 6'd1;
        if (ho_q == 6'(bfd_pkg::HeaderBytes - 1)) begin
          if (hf0_q[31:0] != magic_q) begin
            fail_d = bfd_pkg::StatBadMagic;
          end else if (hf0_q[47:32] != version_q) begin
            fail_d = bfd_pkg::StatBadVersion;
          end else if (k == 32'd0 || k > 32'(MAX_LABELS)) begin
            fail_d = bfd_pkg::StatBadCount;
          end else begin
            main.kind            = bfd_pkg::KindHeader;
            main.sequence_number = hf1_q;
            main.time_bin        = hf2_q[31:0];
            main.valid_word      = hf2_q[63:32];
            main.label_value     = asm_new[31:0];
            main.label_count     = k[16:0];
            event_o.has_main     = 1'b1;
            k_d                  = k[16:0];
            lc_d                 = '0;
          end
        end
      end else if (complete) begin
        main.kind        = bfd_pkg::KindLogit;
        main.logit_index = lc_q[15:0];
        main.logit_bits  = asm_new;
        event_o.has_main = 1'b1;
        lc_d             = lc_next;
        if (lc_next >= k_q) begin
          if (frames_q != CntMax) begin
            frames_d = frames_q + CntW'(1);
          end
          ho_d  = '0;
          lc_d  = '0;
          biw_d = '0;
        end
      end
    end

    event_o.main        = main;
    event_o.has_end     = in_data_i.end_of_buffer;
    event_o.frame_count = 32'(frames_d);
    if (fail_d != bfd_pkg::StatClean) begin
      event_o.status = fail_d;
    end else if (ho_d == '0 && biw_d == '0) begin
      event_o.status = bfd_pkg::StatClean;
    end else begin
      event_o.status = bfd_pkg::StatTruncated;
    end

    if (in_data_i.end_of_buffer) begin
      ho_d     = '0;
      lc_d     = '0;
      biw_d    = '0;
      asm_d    = '0;
      hf0_d    = '0;
      hf1_d    = '0;
      hf2_d    = '0;
      k_d      = '0;
      frames_d = '0;
      fail_d   = bfd_pkg::StatClean;
    end
  end

  assign push_o = accept && (event_o.has_main || event_o.has_end);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ho_q     <= '0;
      lc_q     <= '0;
      biw_q    <= '0;
      asm_q    <= '0;
      hf0_q    <= '0;
      hf1_q    <= '0;
      hf2_q    <= '0;
      k_q      <= '0;
      frames_q <= '0;
      fail_q   <= bfd_pkg::StatClean;
    end else if (accept) begin
      ho_q     <= ho_d;
      lc_q     <= lc_d;
      biw_q    <= biw_d;
      asm_q    <= asm_d;
      hf0_q    <= hf0_d;
      hf1_q    <= hf1_d;
      hf2_q    <= hf2_d;
      k_q      <= k_d;
      frames_q <= frames_d;
      fail_q   <= fail_d;
    end
  end

  a_eob_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_data_i.end_of_buffer) |=>
      (ho_q == '0 && frames_q == '0 && fail_q == bfd_pkg::StatClean))
    else $error("buffer state not cleared after final byte");

  a_fail_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fail_q != bfd_pkg::StatClean && !(accept && in_data_i.end_of_buffer)) |=>
      $stable(fail_q) && $stable(frames_q))
    else $error("failure state changed before end of buffer");

  a_offset_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ho_q <= 6'(bfd_pkg::HeaderBytes))
    else $error("header offset beyond header length");

endmodule

// ----- src/bfd_queue.sv -----
// Two-entry event queue between the byte parser and the result sequencer.
module bfd_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  bfd_pkg::event_t push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output bfd_pkg::event_t head_o
);

  bfd_pkg::event_t mem_q [2];
  logic            wr_q, rd_q;
  logic [1:0]      cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: ;
      endcase
    end
  end

endmodule

// ----- src/bfd_back.sv -----
// Result sequencer: turns each queued event into one or two output words.
module bfd_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  bfd_pkg::event_t q_head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output bfd_pkg::out_t   out_data_o
);

  logic main_done_q, main_done_d;
  logic show_main;
  logic accept;

  assign show_main   = q_head_i.has_main && !main_done_q;
  assign out_valid_o = q_valid_i;
  assign accept      = out_valid_o && out_ready_i;

  always_comb begin
    out_data_o = '0;
    if (show_main) begin
      out_data_o      = q_head_i.main;
      out_data_o.last = !q_head_i.has_end;
    end else begin
      out_data_o.kind        = bfd_pkg::KindEnd;
      out_data_o.frame_count = q_head_i.frame_count;
      out_data_o.status      = q_head_i.status;
      out_data_o.last        = 1'b1;
    end
  end

  always_comb begin
    main_done_d = main_done_q;
    pop_o       = 1'b0;
    if (accept) begin
      if (show_main && q_head_i.has_end) begin
        main_done_d = 1'b1;
      end else begin
        main_done_d = 1'b0;
        pop_o       = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_done_q <= 1'b0;
    end else begin
      main_done_q <= main_done_d;
    end
  end

endmodule

// ----- src/binary_frame_deframer.sv -----
// Top level of the binary frame deframer: byte parser, event queue and result sequencer.
// The block takes one buffer byte per clock cycle while the event queue has room and gives
// one result word per cycle while out_ready_i is high; a final byte that also completes a
// header or logit word yields two words, the end summary after the main one, as the sequencer
// sets. A two-entry event queue parts parser and output, so bytes flow while one event waits.
module binary_frame_deframer #(
  parameter int unsigned MAX_LABELS  = 65536,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [bfd_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [31:0]                 cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  bfd_pkg::in_t                in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output bfd_pkg::out_t               out_data_o
);

  logic            q_full, push, pop, q_valid;
  bfd_pkg::event_t ev, head;

  assign in_ready_o = !q_full;

  bfd_front #(
    .MAX_LABELS (MAX_LABELS),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i),
    .in_data_i (in_data_i),
    .q_full_i  (q_full),
    .push_o    (push),
    .event_o   (ev)
  );

  bfd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(ev),
    .full_o     (q_full),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .head_o     (head)
  );

  bfd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_head_i   (head),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

// ----- tb/sv/deframer_scoreboard_pkg.sv -----
// Scoreboard class that predicts and checks the result words of the binary frame deframer.
package deframer_scoreboard_pkg;
  timeunit 1ns;
  timeprecision 1ps;

  import bfd_pkg::*;

  localparam int unsigned MaxLabels     = 65536;
  localparam logic [31:0] FrameCountMax = 32'hFFFF_FFFF;
  localparam int unsigned MaxReports    = 40;

  class deframer_scoreboard;
    logic [31:0] magic;
    logic [15:0] version;
    logic [5:0]  hdr_offset;
    logic [16:0] logit_count;
    logic [2:0]  byte_pos;
    logic [63:0] shift_word;
    logic [63:0] hdr_words[3];
    logic [31:0] frames;
    status_e     failure;

    out_t        expected_results[$];
    int unsigned errors;
    int unsigned bytes_seen;
    int unsigned headers_seen;
    int unsigned logits_seen;
    int unsigned ends_seen;
    int unsigned status_seen[5];

    function new();
      magic   = '0;
      version = '0;
      clear_buffer();
    endfunction

    function void clear_buffer();
      hdr_offset  = '0;
      logit_count = '0;
      byte_pos    = '0;
      shift_word  = '0;
      foreach (hdr_words[i]) hdr_words[i] = '0;
      frames      = '0;
      failure     = StatClean;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] data);
      if (idx == CfgMagic) begin
        magic = data;
      end else if (idx == CfgVersion) begin
        version = data[15:0];
      end
    endfunction

    function bit idle();
      return expected_results.size() == 0;
    endfunction

    function void note_byte(in_t w);
      out_t        produced[$];
      out_t        r;
      logic [31:0] k;
      bit          complete;
      status_e     st;
      bytes_seen++;
      if (failure == StatClean) begin
        shift_word = {w.data_byte, shift_word[63:8]};
        complete   = (byte_pos == 3'd7);
        byte_pos   = byte_pos + 3'd1;
        if (hdr_offset < HeaderBytes) begin
          if (complete && hdr_offset[4:3] != 2'd3) hdr_words[hdr_offset[4:3]] = shift_word;
          hdr_offset = hdr_offset + 6'd1;
          if (hdr_offset == HeaderBytes) begin
            k = shift_word[63:32];
            if (hdr_words[0][31:0] != magic) begin
              failure = StatBadMagic;
            end else if (hdr_words[0][47:32] != version) begin
              failure = StatBadVersion;
            end else if (k == 0 || k > MaxLabels) begin
              failure = StatBadCount;
            end else begin
              r                 = '0;
              r.kind            = KindHeader;
              r.sequence_number = hdr_words[1];
              r.time_bin        = hdr_words[2][31:0];
              r.valid_word      = hdr_words[2][63:32];
              r.label_value     = shift_word[31:0];
              r.label_count     = k[16:0];
              produced.push_back(r);
              hdr_words[0] = {32'd0, k};
              logit_count  = '0;
            end
          end
        end else if (complete) begin
          r             = '0;
          r.kind        = KindLogit;
          r.logit_index = logit_count[15:0];
          r.logit_bits  = shift_word;
          produced.push_back(r);
          logit_count = logit_count + 17'd1;
          if ({47'd0, logit_count} >= hdr_words[0]) begin
            if (frames != FrameCountMax) frames = frames + 32'd1;
            hdr_offset  = '0;
            logit_count = '0;
            byte_pos    = '0;
          end
        end
      end
      if (w.end_of_buffer) begin
        if (failure != StatClean) begin
          st = failure;
        end else if (hdr_offset == 0 && byte_pos == 0) begin
          st = StatClean;
        end else begin
          st = StatTruncated;
        end
        r             = '0;
        r.kind        = KindEnd;
        r.frame_count = frames;
        r.status      = st;
        produced.push_back(r);
        clear_buffer();
      end
      if (produced.size() > 0) begin
        r      = produced.pop_back();
        r.last = 1'b1;
        produced.push_back(r);
      end
      foreach (produced[i]) expected_results.push_back(produced[i]);
    endfunction

    function void compare_field(string name, logic [63:0] exp, logic [63:0] got);
      if (exp !== got) begin
        errors++;
        if (errors <= MaxReports) begin
          $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp, got);
        end
      end
    endfunction

    function void check_result(out_t got);
      out_t exp;
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= MaxReports) begin
          $display("%0t: unexpected result word, expected none, got %h", $time, got);
        end
        return;
      end
      exp = expected_results.pop_front();
      compare_field("kind", exp.kind, got.kind);
      compare_field("sequence_number", exp.sequence_number, got.sequence_number);
      compare_field("time_bin", exp.time_bin, got.time_bin);
      compare_field("valid_word", exp.valid_word, got.valid_word);
      compare_field("label_value", exp.label_value, got.label_value);
      compare_field("label_count", exp.label_count, got.label_count);
      compare_field("logit_index", exp.logit_index, got.logit_index);
      compare_field("logit_bits", exp.logit_bits, got.logit_bits);
      compare_field("frame_count", exp.frame_count, got.frame_count);
      compare_field("status", exp.status, got.status);
      compare_field("last", exp.last, got.last);
      case (exp.kind)
        KindHeader: headers_seen++;
        KindLogit:  logits_seen++;
        default: begin
          ends_seen++;
          status_seen[exp.status]++;
        end
      endcase
    endfunction
  endclass

endpackage

// ----- tb/sv/tb.sv -----
// Testbench top that feeds byte buffers of frames into the deframer and checks every result word.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bfd_pkg::*;
  import deframer_scoreboard_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  localparam int unsigned StallLimit  = 20000;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned DrainCycles = 20;
  localparam logic [31:0] FullCount   = 32'd65536;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [31:0]         cfg_data_i  = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  in_t                 in_data_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  out_t                out_data_o;

  deframer_scoreboard  sb;
  int                  src_idle     = 0;
  int                  sink_idle    = 0;
  int                  hold_req     = 0;
  int                  hold_seen    = 0;
  int                  hold_left    = 0;
  int                  stall_cycles = 0;
  int unsigned         buffers_sent = 0;
  logic [31:0]         cur_magic    = '0;
  logic [15:0]         cur_version  = '0;

  binary_frame_deframer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (hold_seen != hold_req) begin
      hold_seen   <= hold_req;
      hold_left   <= HoldCycles;
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= sink_idle);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) sb.write_reg(cfg_idx_i, cfg_data_i);
      if (in_valid_i && in_ready_o) sb.note_byte(in_data_i);
      if (out_valid_o && out_ready_i) sb.check_result(out_data_o);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    wait (stall_cycles >= StallLimit);
    $display("%0t: no word moved for %0d cycles", $time, StallLimit);
    $display("*** FAILED ***");
    $finish;
  end

  function automatic void push_le(ref byte_q_t q, input logic [63:0] v, input int n);
    for (int i = 0; i < n; i++) q.push_back(v[8*i +: 8]);
  endfunction

  function automatic void push_header(ref byte_q_t q, input logic [31:0] mg,
                                      input logic [15:0] ver, input logic [31:0] cnt);
    push_le(q, mg, 4);
    push_le(q, ver, 2);
    push_le(q, $urandom, 2);
    push_le(q, {$urandom, $urandom}, 8);
    push_le(q, $urandom, 4);
    push_le(q, $urandom, 4);
    push_le(q, $urandom, 4);
    push_le(q, cnt, 4);
  endfunction

  function automatic void push_frame(ref byte_q_t q, input logic [31:0] cnt,
                                     input int unsigned words);
    push_header(q, cur_magic, cur_version, cnt);
    repeat (words) push_le(q, {$urandom, $urandom}, 8);
  endfunction

  function automatic logic [31:0] pick_count();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 70) return $urandom_range(1, 4);
    if (sel < 95) return $urandom_range(5, 24);
    return $urandom_range(25, 60);
  endfunction

  function automatic void push_good_frames(ref byte_q_t q, input int unsigned n);
    logic [31:0] cnt;
    repeat (n) begin
      cnt = pick_count();
      push_frame(q, cnt, cnt);
    end
  endfunction

  function automatic byte_q_t random_buffer();
    byte_q_t     q;
    byte_q_t     part;
    int unsigned sel;
    int unsigned cut;
    int unsigned words;
    logic [31:0] mg;
    logic [31:0] cnt;
    logic [15:0] ver;
    sel = $urandom_range(99);
    if (sel < 55) begin
      push_good_frames(q, $urandom_range(1, 3));
    end else if (sel < 72) begin
      push_good_frames(q, $urandom_range(0, 2));
      cnt   = ($urandom_range(3) == 0) ? FullCount : pick_count();
      words = (cnt > 3) ? 3 : cnt;
      push_frame(part, cnt, words);
      cut = ($urandom_range(2) == 0) ? HeaderBytes : $urandom_range(1, part.size() - 1);
      for (int i = 0; i < cut; i++) q.push_back(part[i]);
    end else if (sel < 88) begin
      push_good_frames(q, $urandom_range(0, 2));
      mg  = cur_magic;
      ver = cur_version;
      cnt = pick_count();
      case ($urandom_range(2))
        0: begin
          mg = mg ^ (32'd1 << $urandom_range(31));
          if ($urandom_range(1) == 1) ver = ~ver;
        end
        1: ver = ver ^ (16'd1 << $urandom_range(15));
        default: begin
          case ($urandom_range(3))
            0:       cnt = 32'd0;
            1:       cnt = FullCount + 32'd1;
            2:       cnt = 32'h8000_0000 | $urandom;
            default: cnt = 32'h0002_0000 | $urandom;
          endcase
        end
      endcase
      push_header(q, mg, ver, cnt);
      if ($urandom_range(1) == 1) begin
        repeat ($urandom_range(1, 20)) q.push_back($urandom_range(255));
      end
    end else begin
      repeat ($urandom_range(1, 40)) q.push_back($urandom_range(255));
    end
    return q;
  endfunction

  task automatic send_byte(input in_t w);
    while ($urandom_range(99) < src_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_buffer(input byte_q_t q);
    in_t w;
    foreach (q[i]) begin
      w.data_byte     = q[i];
      w.end_of_buffer = (i == q.size() - 1);
      send_byte(w);
    end
    buffers_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (!sb.idle()) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [31:0] mg, input logic [31:0] ver_data);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CfgMagic;
    cfg_data_i <= mg;
    @(posedge clk_i);
    cfg_idx_i  <= CfgVersion;
    cfg_data_i <= ver_data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_magic   = mg;
    cur_version = ver_data[15:0];
  endtask

  task automatic run_random(input int unsigned target);
    int unsigned sent;
    byte_q_t     q;
    sent = 0;
    while (sent < target) begin
      q = random_buffer();
      send_buffer(q);
      sent += q.size();
    end
  endtask

  initial begin
    byte_q_t q;
    sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    q = {8'hFF};
    send_buffer(q);
    q = {};
    push_header(q, 32'd0, 16'd0, FullCount);
    send_buffer(q);
    q = {};
    push_header(q, 32'd0, 16'd0, 32'd0);
    send_buffer(q);

    set_config($urandom, $urandom);
    src_idle  = 30;
    sink_idle = 66;
    hold_req++;
    q = {};
    repeat (3) push_frame(q, 32'd12, 12);
    send_buffer(q);
    run_random(300);

    set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    src_idle  = 66;
    sink_idle = 30;
    run_random(150);
    drain();
    run_random(150);

    set_config(32'd0, {16'($urandom), 16'd0});
    src_idle  = 0;
    sink_idle = 0;
    run_random(250);
    drain();

    $display("Checked %0d bytes in %0d buffers: %0d header, %0d logit and %0d end words.",
             sb.bytes_seen, buffers_sent, sb.headers_seen, sb.logits_seen, sb.ends_seen);
    $display("Statuses: clean %0d, magic %0d, version %0d, count %0d, truncated %0d.",
             sb.status_seen[StatClean], sb.status_seen[StatBadMagic],
             sb.status_seen[StatBadVersion], sb.status_seen[StatBadCount],
             sb.status_seen[StatTruncated]);
    if (sb.errors == 0 && sb.idle()) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
